[rtl/tmlw_pkg.sv]
package tmlw_pkg;

  // Sizing
  localparam int WIDTH_ACC_BITS = 20;
  localparam int ADVANCE_BITS   = 8;
  localparam int SUM_W          = ((WIDTH_ACC_BITS > ADVANCE_BITS) ?
                                   WIDTH_ACC_BITS : ADVANCE_BITS) + 1;
  localparam int TABLE_DEPTH    = 256;
  localparam int QPTR_W         = 2;
  localparam int QUEUE_DEPTH    = 1 << QPTR_W;
  localparam int ADV_ZERO_AS    = 4;

  // Lookahead window: five bytes, a color tag skips four after its opener
  localparam logic [2:0] WIN_LEN  = 3'd5;
  localparam logic [2:0] TAG_SKIP = 3'd4;

  // Input op field codes
  localparam logic IN_OP_TEXT  = 1'b0;
  localparam logic IN_OP_WRITE = 1'b1;

  // Character codes
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_B_UP   = 8'h42;
  localparam logic [7:0] CH_R_UP   = 8'h52;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B_LO   = 8'h62;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R_LO   = 8'h72;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_CLOSE,
    KIND_FINISH,
    KIND_WRITE
  } tmlw_op_kind_t;

  typedef struct packed {
    tmlw_op_kind_t           kind;
    logic [7:0]              code;
    logic [ADVANCE_BITS-1:0] value;
  } tmlw_op_t;

endpackage

[rtl/tmlw_text_if.sv]
interface tmlw_text_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_code;
  logic [7:0] advance_value;
  logic       last;

  modport source (output valid, output op, output char_code, output advance_value,
                  output last, input ready);
  modport sink   (input valid, input op, input char_code, input advance_value,
                  input last, output ready);
endinterface

[rtl/tmlw_result_if.sv]
interface tmlw_result_if;
  logic        valid;
  logic        ready;
  logic [19:0] peak_width;
  logic        saturated;

  modport source (output valid, output peak_width, output saturated, input ready);
  modport sink   (input valid, input peak_width, input saturated, output ready);
endinterface

[rtl/tmlw_front.sv]
module tmlw_front import tmlw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  tmlw_text_if.sink text,
  output logic     push,
  output tmlw_op_t push_data,
  input  logic     q_full
);

  // Length of a line break starting at w[0]; bytes at or past n are absent
  function automatic logic [2:0] break_len(input logic [4:0][7:0] w, input logic [2:0] n);
    logic       v1, v2, v3, v4;
    logic [2:0] len;
    v1  = (n > 3'd1);
    v2  = (n > 3'd2);
    v3  = (n > 3'd3);
    v4  = (n > 3'd4);
    len = 3'd0;
    if (n != 3'd0) begin
      if (w[0] == CH_BSLASH && v1 && w[1] == CH_N) begin
        len = 3'd2;
      end else if (w[0] == CH_CR && v1 && w[1] == CH_LF) begin
        len = 3'd2;
      end else if (w[0] == CH_LF || w[0] == CH_CR) begin
        len = 3'd1;
      end else if (w[0] == CH_LT && v2 && (w[1] == CH_B_LO || w[1] == CH_B_UP) &&
                   (w[2] == CH_R_LO || w[2] == CH_R_UP)) begin
        if (v4 && w[3] == CH_SLASH && w[4] == CH_GT) begin
          len = 3'd5;
        end else if (v3 && w[3] == CH_GT) begin
          len = 3'd4;
        end
      end
    end
    return len;
  endfunction

  logic [4:0][7:0] win, win_next;
  logic [2:0]      cnt, cnt_next;
  logic [2:0]      skip, skip_next;
  logic            draining, draining_next;

  logic            accept, is_write, drain_step;
  logic [4:0][7:0] hw;
  logic [2:0]      hn;
  logic [4:0][7:0] head_w;
  logic [2:0]      head_n;
  logic [2:0]      bl;
  logic            tag;
  logic            head_emit;
  tmlw_op_t        head_op;
  logic [2:0]      head_skip;

  // Handshake: no transfer while the window drains or the queue is full
  assign text.ready = !draining && !q_full;
  assign accept     = text.valid && text.ready;
  assign is_write   = (text.op == IN_OP_WRITE);
  assign drain_step = draining && !q_full;

  // Window with the incoming byte appended
  always_comb begin
    hw      = win;
    hw[cnt] = text.char_code;
  end
  assign hn = cnt + 3'd1;

  // Which window the head logic looks at
  always_comb begin
    if (draining) begin
      head_w = win;
      head_n = cnt;
    end else begin
      head_w = hw;
      head_n = hn;
    end
  end

  // Classify the oldest byte: skip, break, color tag or plain character
  assign bl  = break_len(head_w, head_n);
  assign tag = (head_n == WIN_LEN) && head_w[0] == CH_AT && head_w[4] == CH_AT &&
               break_len({8'h00,  head_w[4:1]}, 3'd4) == 3'd0 &&
               break_len({16'h00, head_w[4:2]}, 3'd3) == 3'd0 &&
               break_len({24'h00, head_w[4:3]}, 3'd2) == 3'd0 &&
               break_len({32'h00, head_w[4:4]}, 3'd1) == 3'd0;

  always_comb begin
    head_emit = 1'b0;
    head_op   = '{kind: KIND_ADD, code: head_w[0], value: '0};
    head_skip = skip;
    if (skip != 3'd0) begin
      head_skip = skip - 3'd1;
    end else if (bl != 3'd0) begin
      head_emit    = 1'b1;
      head_op.kind = KIND_CLOSE;
      head_skip    = bl - 3'd1;
    end else if (tag) begin
      head_skip = TAG_SKIP;
    end else begin
      head_emit = 1'b1;
      if (head_w[0] == CH_BAR) begin
        head_op.code = CH_SPACE;
      end
    end
  end

  // Next state and queue push
  always_comb begin
    win_next      = win;
    cnt_next      = cnt;
    skip_next     = skip;
    draining_next = draining;
    push          = 1'b0;
    push_data     = head_op;
    if (draining) begin
      if (drain_step) begin
        if (cnt == 3'd0) begin
          push           = 1'b1;
          push_data.kind = KIND_FINISH;
          draining_next  = 1'b0;
          skip_next      = 3'd0;
        end else begin
          push      = head_emit;
          skip_next = head_skip;
          win_next  = {8'h00, win[4:1]};
          cnt_next  = cnt - 3'd1;
        end
      end
    end else if (accept) begin
      if (is_write) begin
        push      = 1'b1;
        push_data = '{kind: KIND_WRITE, code: text.char_code,
                      value: ADVANCE_BITS'(text.advance_value)};
      end else begin
        if (hn == WIN_LEN) begin
          push      = head_emit;
          skip_next = head_skip;
          win_next  = {8'h00, hw[4:1]};
          cnt_next  = WIN_LEN - 3'd1;
        end else begin
          win_next = hw;
          cnt_next = hn;
        end
        draining_next = text.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      cnt      <= 3'd0;
      skip     <= 3'd0;
      draining <= 1'b0;
    end else begin
      win      <= win_next;
      cnt      <= cnt_next;
      skip     <= skip_next;
      draining <= draining_next;
    end
  end

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    draining |-> !text.ready)
    else $error("text transfer possible while draining");

  a_window_not_full: assert property (@(posedge clk) disable iff (rst)
    cnt < WIN_LEN)
    else $error("window held five bytes between transfers");

endmodule

[rtl/tmlw_queue.sv]
module tmlw_queue import tmlw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tmlw_op_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output tmlw_op_t q_head
);

  tmlw_op_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_head  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("push into full queue");

endmodule

[rtl/tmlw_back.sv]
module tmlw_back import tmlw_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tmlw_op_t      q_head,
  output logic          pop,
  tmlw_result_if.source result
);

  localparam logic [WIDTH_ACC_BITS-1:0] ACC_LIMIT = '1;

  logic [ADVANCE_BITS-1:0]   adv_mem [TABLE_DEPTH];
  logic [ADVANCE_BITS-1:0]   rd_adv;
  logic                      b_valid;
  tmlw_op_kind_t             b_kind;
  logic [WIDTH_ACC_BITS-1:0] acc;
  logic [WIDTH_ACC_BITS-1:0] widest;
  logic                      sat;
  logic                      out_valid;
  logic [19:0]               out_width;
  logic                      out_sat;

  logic                      out_free, b_done, finish_fire;
  logic [ADVANCE_BITS-1:0]   adv_eff;
  logic [SUM_W-1:0]          sum;
  logic                      sat_hit;
  logic [WIDTH_ACC_BITS-1:0] line_max;

  // Stage control: a finish waits for the output register
  assign out_free    = !out_valid || result.ready;
  assign b_done      = b_valid && (b_kind != KIND_FINISH || out_free);
  assign pop         = q_valid && (!b_valid || b_done);
  assign finish_fire = b_done && (b_kind == KIND_FINISH);

  // Saturating accumulate; a zero entry counts as four
  assign adv_eff  = (rd_adv == '0) ? ADVANCE_BITS'(ADV_ZERO_AS) : rd_adv;
  assign sum      = SUM_W'(acc) + SUM_W'(adv_eff);
  assign sat_hit  = (sum >= SUM_W'(ACC_LIMIT));
  assign line_max = (acc > widest) ? acc : widest;

  // Advance table: write port and registered read
  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_head.kind == KIND_WRITE) begin
        adv_mem[q_head.code] <= q_head.value;
      end
      rd_adv <= adv_mem[q_head.code];
    end
  end

  // Line accumulation stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_kind  <= KIND_ADD;
      acc     <= '0;
      widest  <= '0;
      sat     <= 1'b0;
    end else begin
      if (pop) begin
        b_valid <= (q_head.kind != KIND_WRITE);
        b_kind  <= q_head.kind;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (b_done) begin
        case (b_kind)
          KIND_ADD: begin
            acc <= sat_hit ? ACC_LIMIT : sum[WIDTH_ACC_BITS-1:0];
            if (sat_hit) begin
              sat <= 1'b1;
            end
          end
          KIND_CLOSE: begin
            widest <= line_max;
            acc    <= '0;
          end
          KIND_FINISH: begin
            acc    <= '0;
            widest <= '0;
            sat    <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_width <= 20'(line_max);
      out_sat   <= sat;
    end
  end

  assign result.valid      = out_valid;
  assign result.peak_width = out_width;
  assign result.saturated  = out_sat;

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    finish_fire |=> (acc == '0 && widest == '0 && !sat))
    else $error("stream state not cleared after result");

endmodule

[rtl/text_max_line_width.sv]
// Widest line of a byte string, in pixels.
// Input channel text: one transfer per item. op = 0 carries a text byte in
// char_code, op = 1 writes advance_value into the advance table at char_code.
// last on a text byte ends the string. Every table entry used must be written
// before the text that reads it.
// Result channel result: one transfer per string, carrying peak_width (widest
// line, saturating at the accumulator limit) and saturated.
// Throughput: one item per cycle while text.ready is high. After a byte with
// last the input is held off while the lookahead window empties and the end
// of the string is queued. A four-entry op queue lets the input keep moving
// while the result register is stalled; once it fills, text.ready drops.
// Reset clears the window, line state and pending result. The advance table
// is not cleared and is undefined until written.
module text_max_line_width import tmlw_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  tmlw_text_if.sink     text,
  tmlw_result_if.source result
);

  logic     push, q_full, pop, q_valid;
  tmlw_op_t push_data, q_head;

  tmlw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  tmlw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_head    (q_head)
  );

  tmlw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .result  (result)
  );

endmodule

[tb/text_max_line_width_tb.sv]
`timescale 1ns / 100ps

module text_max_line_width_tb;
  import tmlw_pkg::*;

  // Characters used by the stimulus beyond those in the package
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TOP  = 8'hFF;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_M_LO = 8'h6D;
  localparam logic [7:0] CH_Q_LO = 8'h71;

  localparam int unsigned    NO_CHAR  = 256;
  localparam longint unsigned PX_LIMIT = (64'd1 << WIDTH_ACC_BITS) - 1;
  localparam logic [7:0]     ADV_MASK = 8'((16'd1 << ADVANCE_BITS) - 1);

  typedef struct packed {
    logic [19:0] peak_width;
    logic        saturated;
  } width_res_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  code;
    logic [7:0]  adv;
    logic        last;
    logic        chk;
    logic [19:0] w;
    logic        s;
  } stim_row_t;

  // Directed strings; rows with chk set carry the width read off by hand
  localparam stim_row_t DIR_ROWS [24] = '{
    // one-byte strings: plain lookup, empty line, zero byte on a zero entry, top byte
    '{IN_OP_TEXT, CH_A_LO,   8'd0, 1'b1, 1'b1, 20'd5,   1'b0},
    '{IN_OP_TEXT, CH_LF,     8'd0, 1'b1, 1'b1, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_NUL,    8'd0, 1'b1, 1'b1, 20'd4,   1'b0},
    '{IN_OP_TEXT, CH_TOP,    8'd0, 1'b1, 1'b1, 20'd255, 1'b0},
    // bar and space both use the space entry
    '{IN_OP_TEXT, CH_BAR,    8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_SPACE,  8'd0, 1'b1, 1'b1, 20'd6,   1'b0},
    // backslash-n, then <bR/>, then one byte
    '{IN_OP_TEXT, CH_BSLASH, 8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_N,      8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_LT,     8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_B_LO,   8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_R_UP,   8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_SLASH,  8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_GT,     8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_A_LO,   8'd0, 1'b1, 1'b1, 20'd5,   1'b0},
    // lone CR, a color tag, then one byte
    '{IN_OP_TEXT, CH_CR,     8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_AT,     8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_Q_LO,   8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_Q_LO,   8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_Q_LO,   8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_AT,     8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT, CH_A_LO,   8'd0, 1'b1, 1'b1, 20'd5,   1'b0},
    // table write mid-string hits the byte already in the window; its last is ignored
    '{IN_OP_TEXT,  CH_A_LO,  8'd0, 1'b0, 1'b0, 20'd0,   1'b0},
    '{IN_OP_WRITE, CH_A_LO,  8'd9, 1'b1, 1'b0, 20'd0,   1'b0},
    '{IN_OP_TEXT,  CH_A_LO,  8'd0, 1'b1, 1'b1, 20'd18,  1'b0}
  };

  logic clk;
  logic rst;

  tmlw_text_if   text_ch();
  tmlw_result_if result_ch();

  text_max_line_width i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch.sink),
    .result (result_ch.source)
  );

  // Line-width state mirrored from the block
  logic [7:0]      adv_tab [TABLE_DEPTH];
  logic [7:0]      look_win [5];
  int unsigned     look_n;
  int unsigned     skip_left;
  longint unsigned line_px;
  longint unsigned widest_px;
  logic            sat_hit;

  width_res_t pending_widths[$];
  int         mism;
  int         items_sent;
  bit         idle_on;
  bit         hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned char_at(int unsigned off, int unsigned k);
    return (off + k < look_n) ? int'(look_win[off + k]) : NO_CHAR;
  endfunction

  // Length of the line break starting at window slot off, 0 if none
  function automatic int unsigned break_len_at(int unsigned off);
    int unsigned c0, c1, c2, c3, c4;
    if (off >= look_n) return 0;
    c0 = char_at(off, 0);
    c1 = char_at(off, 1);
    c2 = char_at(off, 2);
    c3 = char_at(off, 3);
    c4 = char_at(off, 4);
    if (c0 == CH_BSLASH && c1 == CH_N) return 2;
    if (c0 == CH_CR && c1 == CH_LF) return 2;
    if (c0 == CH_LF || c0 == CH_CR) return 1;
    if (c0 == CH_LT && (c1 == CH_B_LO || c1 == CH_B_UP) &&
        (c2 == CH_R_LO || c2 == CH_R_UP)) begin
      if (c3 == CH_SLASH && c4 == CH_GT) return 5;
      if (c3 == CH_GT) return 4;
    end
    return 0;
  endfunction

  function automatic void close_line();
    if (line_px > widest_px) widest_px = line_px;
    line_px = 0;
  endfunction

  // Retire the oldest byte of the window
  function automatic void consume_head();
    int unsigned     bl;
    logic [7:0]      idx;
    longint unsigned px;
    int              k;
    if (look_n == 0) return;
    bl = break_len_at(0);
    if (skip_left > 0) begin
      skip_left--;
    end else if (bl > 0) begin
      close_line();
      skip_left = bl - 1;
    end else if (look_n >= WIN_LEN && look_win[0] == CH_AT && look_win[4] == CH_AT &&
                 break_len_at(1) == 0 && break_len_at(2) == 0 &&
                 break_len_at(3) == 0 && break_len_at(4) == 0) begin
      skip_left = TAG_SKIP;
    end else begin
      idx = (look_win[0] == CH_SPACE || look_win[0] == CH_BAR) ? CH_SPACE : look_win[0];
      px  = (adv_tab[idx] == 8'd0) ? ADV_ZERO_AS : adv_tab[idx];
      px  = line_px + px;
      if (px >= PX_LIMIT) begin
        px      = PX_LIMIT;
        sat_hit = 1'b1;
      end
      line_px = px;
    end
    for (k = 0; k < 4; k++) look_win[k] = look_win[k + 1];
    look_win[4] = 8'd0;
    look_n--;
  endfunction

  // Apply one accepted item; a text byte with last queues the expected width
  function automatic void line_width_step(logic op, logic [7:0] code, logic [7:0] adv,
                                          logic last);
    width_res_t r;
    if (op == IN_OP_WRITE) begin
      adv_tab[code] = adv & ADV_MASK;
      return;
    end
    if (look_n >= WIN_LEN) consume_head();
    look_win[look_n] = code;
    look_n++;
    if (look_n >= WIN_LEN) consume_head();
    if (!last) return;
    while (look_n > 0) consume_head();
    close_line();
    r.peak_width = widest_px[19:0];
    r.saturated  = sat_hit;
    pending_widths.push_back(r);
    foreach (look_win[k]) look_win[k] = 8'd0;
    look_n    = 0;
    skip_left = 0;
    line_px   = 0;
    widest_px = 0;
    sat_hit   = 1'b0;
  endfunction

  function automatic void check_width(logic [19:0] w, logic s);
    width_res_t e;
    if (pending_widths.size() == 0) begin
      mism++;
      if (mism <= 10)
        $display("%0t: unexpected result peak_width=%0d saturated=%0d", $realtime, w, s);
    end else begin
      e = pending_widths.pop_front();
      if (w !== e.peak_width || s !== e.saturated) begin
        mism++;
        if (mism <= 10)
          $display("%0t: peak_width exp %0d got %0d, saturated exp %0d got %0d",
                   $realtime, e.peak_width, w, e.saturated, s);
      end
    end
  endfunction

  function automatic logic [7:0] rand_advance();
    return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  // Offer one item from a falling edge and return at the falling edge after its transfer
  task automatic send_item(input logic op, input logic [7:0] code, input logic [7:0] adv,
                           input logic last, input bit typed = 1'b0,
                           input logic [19:0] typed_w = '0, input logic typed_s = 1'b0);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    text_ch.valid         <= 1'b1;
    text_ch.op            <= op;
    text_ch.char_code     <= code;
    text_ch.advance_value <= adv;
    text_ch.last          <= last;
    do @(posedge clk); while (!(text_ch.ready === 1'b1));
    line_width_step(op, code, adv, last);
    if (typed) pending_widths[$] = '{typed_w, typed_s};
    items_sent++;
    @(negedge clk);
  endtask

  // One string built from tokens: plain bytes, breaks, tags and broken prefixes
  task automatic send_random_string();
    logic [7:0]  txt[$];
    logic [7:0]  b_ch, r_ch;
    int unsigned n_tok, k;
    n_tok = $urandom_range(1, 6);
    for (k = 0; k < n_tok; k++) begin
      b_ch = $urandom_range(0, 1) ? CH_B_UP : CH_B_LO;
      r_ch = $urandom_range(0, 1) ? CH_R_UP : CH_R_LO;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
        4: begin
          txt.push_back(CH_BSLASH);
          txt.push_back(CH_N);
        end
        5: case ($urandom_range(0, 2))
          0: begin
            txt.push_back(CH_CR);
            txt.push_back(CH_LF);
          end
          1: txt.push_back(CH_LF);
          default: txt.push_back(CH_CR);
        endcase
        6: begin
          txt.push_back(CH_LT);
          txt.push_back(b_ch);
          txt.push_back(r_ch);
          if ($urandom_range(0, 1)) txt.push_back(CH_SLASH);
          txt.push_back(CH_GT);
        end
        7: begin
          txt.push_back(CH_AT);
          repeat (3) txt.push_back(8'($urandom_range(0, 255)));
          txt.push_back(CH_AT);
        end
        8: begin
          // prefix of a break or a tag that goes wrong
          case ($urandom_range(0, 2))
            0: begin
              txt.push_back(CH_LT);
              txt.push_back(b_ch);
              txt.push_back(r_ch);
            end
            1: begin
              txt.push_back(CH_AT);
              txt.push_back(8'($urandom_range(0, 255)));
              txt.push_back(CH_AT);
            end
            default: txt.push_back(CH_BSLASH);
          endcase
          txt.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          txt.push_back(CH_SPACE);
          txt.push_back(CH_BAR);
        end
      endcase
    end
    for (k = 0; k < txt.size(); k++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(IN_OP_WRITE, 8'($urandom_range(0, 255)), rand_advance(),
                  1'($urandom_range(0, 1)));
      send_item(IN_OP_TEXT, txt[k], 8'($urandom_range(0, 255)), k == txt.size() - 1);
    end
  endtask

  // Result side: random ready bursts, one long hold-off on request
  initial begin : result_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        check_width(result_ch.peak_width, result_ch.saturated);
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : run_limit
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int         i;
    int         target;
    logic [7:0] v;
    mism       = 0;
    items_sent = 0;
    idle_on    = 1'b0;
    hold_req   = 1'b0;
    look_n     = 0;
    skip_left  = 0;
    line_px    = 0;
    widest_px  = 0;
    sat_hit    = 1'b0;
    foreach (look_win[k]) look_win[k] = 8'd0;
    foreach (adv_tab[k]) adv_tab[k] = 8'd0;
    rst                   = 1'b1;
    text_ch.valid         = 1'b0;
    text_ch.op            = IN_OP_TEXT;
    text_ch.char_code     = 8'd0;
    text_ch.advance_value = 8'd0;
    text_ch.last          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Write every table entry; a few get fixed values the directed strings rely on
    for (i = 0; i < TABLE_DEPTH; i++) begin
      v = rand_advance();
      case (8'(i))
        CH_NUL:   v = 8'd0;
        CH_TOP:   v = 8'd255;
        CH_SPACE: v = 8'd3;
        CH_BAR:   v = 8'd200;
        CH_A_LO:  v = 8'd5;
        default: ;
      endcase
      send_item(IN_OP_WRITE, 8'(i), v, 1'($urandom_range(0, 1)));
    end

    foreach (DIR_ROWS[k])
      send_item(DIR_ROWS[k].op, DIR_ROWS[k].code, DIR_ROWS[k].adv, DIR_ROWS[k].last,
                DIR_ROWS[k].chk, DIR_ROWS[k].w, DIR_ROWS[k].s);

    target = items_sent + 300;
    while (items_sent < target) send_random_string();

    // Long result hold-off while strings keep coming: the op queue fills and input stalls
    hold_req = 1'b1;
    repeat (15) send_random_string();

    // Long line of wide characters, then a break and a short line
    send_item(IN_OP_WRITE, CH_M_LO, 8'hFF, 1'b0);
    repeat (100) send_item(IN_OP_TEXT, CH_M_LO, 8'($urandom_range(0, 255)), 1'b0);
    send_item(IN_OP_TEXT, CH_LF, 8'd0, 1'b0);
    send_item(IN_OP_TEXT, CH_A_LO, 8'd0, 1'b1);

    target = items_sent + 220;
    while (items_sent < target) send_random_string();

    // Closing stretch at full rate on both sides
    idle_on = 1'b0;
    target  = items_sent + 200;
    while (items_sent < target) send_random_string();
    text_ch.valid <= 1'b0;

    while (pending_widths.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mism == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
